[src/rbe_pkg.sv]
// Shared types, constants and fixed-point helpers for the rigid body integrator.
`timescale 1ns / 1ps
package rbe_pkg;

  localparam int DefMaxBodies = 256;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [1:0] REG_GRAVITY  = 2'd0;
  localparam logic [1:0] REG_DAMPING  = 2'd1;
  localparam logic [1:0] REG_BOUNCE   = 2'd2;
  localparam logic [1:0] REG_FRICTION = 2'd3;

  localparam logic [30:0] GRAVITY_RST  = 31'd6429082;
  localparam logic [15:0] DAMPING_RST  = 16'd64881;
  localparam logic [15:0] BOUNCE_RST   = 16'd32768;
  localparam logic [15:0] FRICTION_RST = 16'd62259;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic [30:0]        extent_z;
    logic [15:0]        time_step;
    logic [7:0]         body_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         body_id;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [30:0]        out_size_x;
    logic [30:0]        out_size_y;
    logic [30:0]        out_size_z;
    logic [8:0]         body_total;
  } out_item_t;

  typedef struct packed {
    logic [30:0] gravity;
    logic [15:0] damping;
    logic [15:0] bounce;
    logic [15:0] friction;
  } cfg_t;

  // Saturate a 50-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Round a Q16.16 by Q0.16 product (50 bits signed) back to Q16.16.
  function automatic logic signed [31:0] rnd_q16(input logic signed [49:0] p);
    logic signed [49:0] x;
    x = p + 50'sd32768;
    return sat32(x >>> 16);
  endfunction

endpackage

[src/rigid_body_euler_integrator.sv]
// Top level of the rigid body integrator: configuration registers, front and back.
`timescale 1ns / 1ps
// Clear, add and failed reads go straight to the result; a good read first reads the body
// memories; a step walks each stored body, reusing one shared multiplier ten times per body
// between the memory read and the write back. The back end takes one item at a time, none
// while a result is held; the 2-entry queue keeps accepting until it is full.
// Reset (synchronous, rst_n low): registers return to defaults, the table is empty;
// the body memories hold no reset value and only entries below the body count are used.
module rigid_body_euler_integrator #(
  parameter int MaxBodies = rbe_pkg::DefMaxBodies
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rbe_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output rbe_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import rbe_pkg::*;

  localparam int CntW = $clog2(MaxBodies + 1);

  cfg_t cfg_r;
  logic cfg_wr;
  logic [1:0] reg_idx;

  // Registers sit on word addresses; a write lands on the access phase.
  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[3:2];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity <= GRAVITY_RST;
      cfg_r.damping <= DAMPING_RST;
      cfg_r.bounce <= BOUNCE_RST;
      cfg_r.friction <= FRICTION_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRAVITY:  cfg_r.gravity <= cfg_pwdata[30:0];
        REG_DAMPING:  cfg_r.damping <= cfg_pwdata[15:0];
        REG_BOUNCE:   cfg_r.bounce <= cfg_pwdata[15:0];
        REG_FRICTION: cfg_r.friction <= cfg_pwdata[15:0];
        default: begin end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRAVITY:  cfg_prdata = {1'b0, cfg_r.gravity};
      REG_DAMPING:  cfg_prdata = {16'd0, cfg_r.damping};
      REG_BOUNCE:   cfg_prdata = {16'd0, cfg_r.bounce};
      REG_FRICTION: cfg_prdata = {16'd0, cfg_r.friction};
      default:      cfg_prdata = '0;
    endcase
  end

  // The front end updates the count at transfer time, so the queue carries
  // each command already classified with its status.
  logic            q_valid, q_take;
  in_item_t        q_item;
  logic [1:0]      q_status;
  logic [CntW-1:0] q_count;

  rbe_front #(.MaxBodies(MaxBodies)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .q_valid, .q_take, .q_item, .q_status, .q_count
  );

  rbe_back #(.MaxBodies(MaxBodies)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_take, .q_item, .q_status, .q_count,
    .out_empty, .out_pop, .out_data
  );
endmodule

[src/rbe_front.sv]
// Front end: accepts items, keeps the body count, classifies and queues commands.
`timescale 1ns / 1ps
module rbe_front #(
  parameter int MaxBodies = rbe_pkg::DefMaxBodies,
  parameter int IdxW = $clog2(MaxBodies),
  parameter int CntW = $clog2(MaxBodies + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  rbe_pkg::in_item_t in_data,
  output logic             q_valid,
  input  logic             q_take,
  output rbe_pkg::in_item_t q_item,
  output logic [1:0]       q_status,
  output logic [CntW-1:0]  q_count
);
  import rbe_pkg::*;

  localparam int QDepth = 2;

  in_item_t        qi_r    [QDepth];
  logic [1:0]      qs_r    [QDepth];
  logic [CntW-1:0] qc_r    [QDepth];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      fill_r, fill_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            acc;
  logic [1:0]      st;

  assign in_full = (fill_r == 2'(QDepth));
  assign acc     = in_push && !in_full;
  assign q_valid = (fill_r != 2'd0);
  assign q_item  = qi_r[rp_r];
  assign q_status = qs_r[rp_r];
  assign q_count = qc_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    st = ST_OK;
    unique case (in_data.opcode)
      OP_CLEAR: cnt_nxt = '0;
      OP_ADD: begin
        if (cnt_r == CntW'(MaxBodies)) st = ST_FULL;
        else cnt_nxt = cnt_r + 1'b1;
      end
      OP_STEP: st = ST_OK;
      OP_READ: begin
        if ({{(32-8){1'b0}}, in_data.body_select} >= {{(32-CntW){1'b0}}, cnt_r})
          st = ST_BAD;
      end
      default: st = ST_OK;
    endcase
    wp_nxt = acc ? ~wp_r : wp_r;
    rp_nxt = (q_take && q_valid) ? ~rp_r : rp_r;
    fill_nxt = fill_r + (acc ? 2'd1 : 2'd0) - ((q_take && q_valid) ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      fill_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      fill_r <= fill_nxt;
      if (acc) cnt_r <= cnt_nxt;
    end
  end

  // Each entry holds the command, its status and the count (pre-add for an add).
  always_ff @(posedge clk) begin
    if (acc) begin
      qi_r[wp_r] <= in_data;
      qs_r[wp_r] <= st;
      qc_r[wp_r] <= (in_data.opcode == OP_ADD && st == ST_OK) ? cnt_r : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (fill_r <= 2'(QDepth)) else $error("queue overfilled");
    end
  end
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxBodies)) else $error("count beyond table");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_valid) else $error("full without entries");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.opcode == OP_CLEAR |=> cnt_r == '0) else $error("clear lost");
endmodule

[src/rbe_back.sv]
// Back end: body memories, step sequencer with a shared multiplier, result register.
`timescale 1ns / 1ps
module rbe_back #(
  parameter int MaxBodies = rbe_pkg::DefMaxBodies,
  parameter int IdxW = $clog2(MaxBodies),
  parameter int CntW = $clog2(MaxBodies + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rbe_pkg::cfg_t     cfg,
  input  logic              q_valid,
  output logic              q_take,
  input  rbe_pkg::in_item_t q_item,
  input  logic [1:0]        q_status,
  input  logic [CntW-1:0]   q_count,
  output logic              out_empty,
  input  logic              out_pop,
  output rbe_pkg::out_item_t out_data
);
  import rbe_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // memory read data taken into the working registers
  localparam logic [3:0] S_GDT  = 4'd2;  // g*dt
  localparam logic [3:0] S_DX   = 4'd3;  // damp vx
  localparam logic [3:0] S_DY   = 4'd4;  // damp vy (after gravity)
  localparam logic [3:0] S_DZ   = 4'd5;
  localparam logic [3:0] S_PX   = 4'd6;
  localparam logic [3:0] S_PY   = 4'd7;
  localparam logic [3:0] S_PZ   = 4'd8;
  localparam logic [3:0] S_BY   = 4'd9;  // bounce vy
  localparam logic [3:0] S_FX   = 4'd10;
  localparam logic [3:0] S_FZ   = 4'd11;
  localparam logic [3:0] S_WB   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic signed [31:0] px_m [MaxBodies];
  logic signed [31:0] py_m [MaxBodies];
  logic signed [31:0] pz_m [MaxBodies];
  logic signed [31:0] vx_m [MaxBodies];
  logic signed [31:0] vy_m [MaxBodies];
  logic signed [31:0] vz_m [MaxBodies];
  logic [30:0]        sx_m [MaxBodies];
  logic [30:0]        sy_m [MaxBodies];
  logic [30:0]        sz_m [MaxBodies];

  logic signed [31:0] px_q, py_q, pz_q, vx_q, vy_q, vz_q;
  logic [30:0]        sx_q, sy_q, sz_q;

  logic [3:0]         st_r, st_nxt;
  logic [IdxW-1:0]    idx_r, idx_nxt;
  logic [IdxW-1:0]    rd_idx;
  logic signed [31:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r;
  in_item_t           cmd_r;
  logic [1:0]         cst_r;
  logic [CntW-1:0]    ccnt_r;
  out_item_t          res_r, res_nxt;
  logic               full_r;
  logic               wr_body, wr_add;

  // Shared multiplier: one signed 33x17 product per cycle, registered result.
  logic signed [32:0] ma;
  logic signed [16:0] mb;
  logic signed [49:0] prod_r;
  logic signed [31:0] rp;
  logic signed [31:0] half;

  assign out_empty = !full_r;
  assign out_data  = res_r;
  assign q_take    = q_valid && st_r == S_IDLE && !full_r;
  assign rp        = rnd_q16(prod_r);
  assign half      = {2'b00, sy_q[30:1]};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      S_GDT: begin ma = {2'b00, cfg.gravity}; mb = {1'b0, cmd_r.time_step}; end
      S_DX:  begin ma = 33'(vx_q); mb = {1'b0, cfg.damping}; end
      S_DY:  begin ma = 33'(vy_r); mb = {1'b0, cfg.damping}; end
      S_DZ:  begin ma = 33'(vz_q); mb = {1'b0, cfg.damping}; end
      S_PX:  begin ma = 33'(vx_r); mb = {1'b0, cmd_r.time_step}; end
      S_PY:  begin ma = 33'(vy_r); mb = {1'b0, cmd_r.time_step}; end
      S_PZ:  begin ma = 33'(vz_r); mb = {1'b0, cmd_r.time_step}; end
      S_BY:  begin ma = -33'(vy_r); mb = {1'b0, cfg.bounce}; end
      S_FX:  begin ma = 33'(vx_r); mb = {1'b0, cfg.friction}; end
      S_FZ:  begin ma = 33'(vz_r); mb = {1'b0, cfg.friction}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      S_IDLE: if (q_take) begin
        if (q_item.opcode == OP_STEP && q_count != '0) st_nxt = S_RD;
        else if (q_item.opcode == OP_READ && q_status == ST_OK) st_nxt = S_RD;
        else st_nxt = S_OUT;
        idx_nxt = (q_item.opcode == OP_READ) ? IdxW'(q_item.body_select) : '0;
      end
      S_RD:  st_nxt = (cmd_r.opcode == OP_READ) ? S_OUT : S_GDT;
      S_GDT: st_nxt = S_DX;
      S_DX:  st_nxt = S_DY;
      S_DY:  st_nxt = S_DZ;
      S_DZ:  st_nxt = S_PX;
      S_PX:  st_nxt = S_PY;
      S_PY:  st_nxt = S_PZ;
      S_PZ:  st_nxt = S_BY;
      S_BY:  st_nxt = S_FX;
      S_FX:  st_nxt = S_FZ;
      S_FZ:  st_nxt = S_WB;
      S_WB: begin
        if ({{(32-IdxW){1'b0}}, idx_r} + 32'd1 >= {{(32-CntW){1'b0}}, ccnt_r})
          st_nxt = S_OUT;
        else begin
          st_nxt = S_RD;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // The read address follows the body being worked on, so the read registers
  // keep that body's stored values for the whole update or read.
  assign rd_idx = idx_nxt;

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    px_q <= px_m[rd_idx]; py_q <= py_m[rd_idx]; pz_q <= pz_m[rd_idx];
    vx_q <= vx_m[rd_idx]; vy_q <= vy_m[rd_idx]; vz_q <= vz_m[rd_idx];
    sx_q <= sx_m[rd_idx]; sy_q <= sy_m[rd_idx]; sz_q <= sz_m[rd_idx];
  end

  // Datapath registers; each update state from damp vx on consumes the product issued in the state before.
  logic ground;
  assign ground = ($signed({py_r[31], py_r}) - $signed({1'b0, half})) <= 33'sd0;

  // Body memories share one write port: add writes a new body, WB writes back.
  logic [IdxW-1:0] wa;
  assign wr_add  = q_take && q_item.opcode == OP_ADD && q_status == ST_OK;
  assign wr_body = st_r == S_WB;
  assign wa      = wr_add ? q_count[IdxW-1:0] : idx_r;
  always_ff @(posedge clk) begin
    if (wr_add) begin
      px_m[wa] <= q_item.start_x; py_m[wa] <= q_item.start_y; pz_m[wa] <= q_item.start_z;
      vx_m[wa] <= '0; vy_m[wa] <= '0; vz_m[wa] <= '0;
      sx_m[wa] <= q_item.extent_x; sy_m[wa] <= q_item.extent_y;
      sz_m[wa] <= q_item.extent_z;
    end else if (wr_body) begin
      px_m[wa] <= px_r; py_m[wa] <= py_r; pz_m[wa] <= pz_r;
      vx_m[wa] <= vx_r; vy_m[wa] <= vy_r; vz_m[wa] <= ground ? rp : vz_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (q_take) begin
        cmd_r <= q_item; cst_r <= q_status; ccnt_r <= q_count;
      end
      S_RD: begin px_r <= px_q; py_r <= py_q; pz_r <= pz_q; vy_r <= vy_q; end
      S_DX: vy_r <= sat32(50'(vy_r) - 50'(rp));
      S_DY: vx_r <= rp;
      S_DZ: vy_r <= rp;
      S_PX: vz_r <= rp;
      S_PY: px_r <= sat32(50'(px_r) + 50'(rp));
      S_PZ: py_r <= sat32(50'(py_r) + 50'(rp));
      S_BY: pz_r <= sat32(50'(pz_r) + 50'(rp));
      S_FX: if (ground) begin vy_r <= rp; py_r <= half; end
      S_FZ: if (ground) vx_r <= rp;
      S_WB: if (ground) vz_r <= rp;
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      idx_r <= '0;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      if (st_r == S_OUT) full_r <= 1'b1;
      else if (out_pop && full_r) full_r <= 1'b0;
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = cst_r;
    res_nxt.body_total = 9'(ccnt_r);
    if (cmd_r.opcode == OP_ADD && cst_r == ST_OK) begin
      res_nxt.body_id = 8'(ccnt_r);
      res_nxt.body_total = 9'(ccnt_r + 1'b1);
    end
    if (cmd_r.opcode == OP_READ) begin
      res_nxt.body_id = cmd_r.body_select;
      if (cst_r == ST_OK) begin
        res_nxt.out_x = px_r; res_nxt.out_y = py_r; res_nxt.out_z = pz_r;
        res_nxt.out_size_x = sx_q; res_nxt.out_size_y = sy_q; res_nxt.out_size_z = sz_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT) res_r <= res_nxt;
  end

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !full_r) else $error("took item over held result");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_OUT |=> full_r) else $error("result not posted");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_WB |-> {{(32-IdxW){1'b0}}, idx_r} < {{(32-CntW){1'b0}}, ccnt_r})
    else $error("step past table");
endmodule
